// ----- rtl/wto_pkg.sv -----
// shared types and constants of the wavetable oscillator
`default_nettype none

package wto_pkg;

  // table geometry
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned INDEX_BITS  = 10;
  localparam int unsigned LEN_BITS    = 11;

  // sample and phase formats
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned PHASE_BITS  = INDEX_BITS + FRAC_BITS;
  localparam int unsigned INC_BITS    = 26;
  localparam int unsigned SPAN_BITS   = PHASE_BITS + 1;

  // remainder unit: quotient of a 27-bit sum by span needs 11 bits
  localparam int unsigned DIV_STEPS = SPAN_BITS - FRAC_BITS;
  localparam int unsigned DIV_CNT_BITS = 4;

  // item queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = 2;
  localparam int unsigned QCNT_BITS   = 3;

  // stream widths
  localparam int unsigned S_TDATA_BITS = 32;
  localparam int unsigned M_TDATA_BITS = 16;

  // configuration port
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 26;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_INC = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INTERP    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TABLE_LEN = 2'd2;

  // item kinds
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  // phase unit states
  typedef enum logic [1:0] {
    PH_RUN,
    PH_DIV,
    PH_HOLD
  } ph_state_e;

  // classified item in the queue
  typedef struct packed {
    op_e                            op;
    logic [INDEX_BITS-1:0]          index;
    logic signed [SAMPLE_BITS-1:0]  value;
  } item_t;

  // item leaving the phase unit
  typedef struct packed {
    logic                           tick;
    logic                           zero;
    logic [PHASE_BITS-1:0]          phase;
    logic [INDEX_BITS-1:0]          index;
    logic signed [SAMPLE_BITS-1:0]  value;
  } ph_item_t;

endpackage

`default_nettype wire

// ----- rtl/wto_front.sv -----
// front end: stream intake, item classification and item queue
`default_nettype none

module wto_front (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // tdata: table_index [9:0], table_value [25:10], zero fill above
  input  wire logic [wto_pkg::S_TDATA_BITS-1:0]       s_axis_tdata,
  // tuser: operation
  input  wire logic                                   s_axis_tuser,
  output logic                                        q_valid_o,
  output wto_pkg::item_t                              q_item_o,
  input  wire logic                                   q_pop_i
);

  wto_pkg::item_t                        mem_q [wto_pkg::QUEUE_DEPTH];
  wto_pkg::item_t                        item_in;
  logic [wto_pkg::QPTR_BITS-1:0]         wr_ptr_q, wr_ptr_d;
  logic [wto_pkg::QPTR_BITS-1:0]         rd_ptr_q, rd_ptr_d;
  logic [wto_pkg::QCNT_BITS-1:0]         cnt_q, cnt_d;
  logic                                  push;

  // classify the incoming transfer
  always_comb begin
    item_in.op    = s_axis_tuser ? wto_pkg::OP_LOAD : wto_pkg::OP_TICK;
    item_in.index = s_axis_tdata[wto_pkg::INDEX_BITS-1:0];
    item_in.value = $signed(s_axis_tdata[wto_pkg::INDEX_BITS +: wto_pkg::SAMPLE_BITS]);
  end

  assign s_axis_tready = (cnt_q != wto_pkg::QCNT_BITS'(wto_pkg::QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != '0);
  assign q_item_o      = mem_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = q_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + wto_pkg::QCNT_BITS'(push) - wto_pkg::QCNT_BITS'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wto_phase.sv -----
// phase accumulator with wrap by table span and iterative remainder unit
`default_nettype none

module wto_phase (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              q_valid_i,
  input  wire wto_pkg::item_t                    q_item_i,
  output logic                                   q_pop_o,
  input  wire logic [wto_pkg::INC_BITS-1:0]      inc_i,
  input  wire logic [wto_pkg::LEN_BITS-1:0]      len_i,
  input  wire logic                              adv_i,
  output logic                                   ph_valid_o,
  output wto_pkg::ph_item_t                      ph_item_o
);

  localparam int unsigned SHIFT_BITS = wto_pkg::SPAN_BITS + wto_pkg::DIV_STEPS - 1;

  wto_pkg::ph_state_e                      state_q, state_d;
  logic [wto_pkg::PHASE_BITS-1:0]          phase_q, phase_d;
  logic [wto_pkg::SPAN_BITS-1:0]           div_x_q, div_x_d;
  logic [wto_pkg::DIV_CNT_BITS-1:0]        div_cnt_q, div_cnt_d;
  logic                                    out_valid_q, out_valid_d;
  wto_pkg::ph_item_t                       out_q, out_d;

  logic [wto_pkg::SPAN_BITS-1:0]           span;
  logic [wto_pkg::SPAN_BITS-1:0]           sum;
  logic [wto_pkg::SPAN_BITS-1:0]           wrap;
  logic                                    fast;
  logic [SHIFT_BITS-1:0]                   div_sub;
  logic                                    div_ge;
  logic [wto_pkg::SPAN_BITS-1:0]           div_next;

  // one-step wrap, valid when phase and increment both lie below span
  always_comb begin
    span = {len_i, wto_pkg::FRAC_BITS'(0)};
    sum  = {1'b0, phase_q} + wto_pkg::SPAN_BITS'(inc_i);
    fast = ({1'b0, phase_q} < span) && (wto_pkg::SPAN_BITS'(inc_i) < span);
    wrap = (sum >= span) ? sum - span : sum;
  end

  // restoring remainder step, one quotient bit a cycle
  always_comb begin
    div_sub  = SHIFT_BITS'(span) << div_cnt_q;
    div_ge   = SHIFT_BITS'(div_x_q) >= div_sub;
    div_next = div_ge ? div_x_q - div_sub[wto_pkg::SPAN_BITS-1:0] : div_x_q;
  end

  // next state and outputs
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    div_x_d     = div_x_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = adv_i ? 1'b0 : out_valid_q;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    case (state_q)
      wto_pkg::PH_RUN: begin
        if (adv_i && q_valid_i) begin
          q_pop_o     = 1'b1;
          out_d.index = q_item_i.index;
          out_d.value = q_item_i.value;
          out_d.phase = phase_q;
          out_d.zero  = 1'b0;
          if (q_item_i.op == wto_pkg::OP_LOAD) begin
            out_valid_d = 1'b1;
            out_d.tick  = 1'b0;
          end else if (len_i == '0) begin
            out_valid_d = 1'b1;
            out_d.tick  = 1'b1;
            out_d.zero  = 1'b1;
          end else if (fast) begin
            out_valid_d = 1'b1;
            out_d.tick  = 1'b1;
            out_d.phase = wrap[wto_pkg::PHASE_BITS-1:0];
            phase_d     = wrap[wto_pkg::PHASE_BITS-1:0];
          end else begin
            div_x_d   = sum;
            div_cnt_d = wto_pkg::DIV_CNT_BITS'(wto_pkg::DIV_STEPS - 1);
            state_d   = wto_pkg::PH_DIV;
          end
        end
      end
      wto_pkg::PH_DIV: begin
        div_x_d = div_next;
        if (div_cnt_q == '0) begin
          state_d = wto_pkg::PH_HOLD;
        end else begin
          div_cnt_d = div_cnt_q - 1'b1;
        end
      end
      wto_pkg::PH_HOLD: begin
        if (adv_i) begin
          out_valid_d = 1'b1;
          out_d.tick  = 1'b1;
          out_d.zero  = 1'b0;
          out_d.phase = div_x_q[wto_pkg::PHASE_BITS-1:0];
          phase_d     = div_x_q[wto_pkg::PHASE_BITS-1:0];
          state_d     = wto_pkg::PH_RUN;
        end
      end
      default: begin
        state_d = wto_pkg::PH_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wto_pkg::PH_RUN;
      phase_q     <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    div_x_q <= div_x_d;
    out_q   <= out_d;
  end

  assign ph_valid_o = out_valid_q;
  assign ph_item_o  = out_q;

endmodule

`default_nettype wire

// ----- rtl/wto_mix.sv -----
// wave table memory, linear interpolation and output register
`default_nettype none

module wto_mix (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                ph_valid_i,
  input  wire wto_pkg::ph_item_t                   ph_item_i,
  input  wire logic                                interp_i,
  input  wire logic [wto_pkg::LEN_BITS-1:0]        len_i,
  output logic                                     adv_o,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // tdata: sample
  output logic [wto_pkg::M_TDATA_BITS-1:0]         m_axis_tdata
);

  localparam int unsigned PROD_BITS = 2 * (wto_pkg::SAMPLE_BITS + 1);

  logic signed [wto_pkg::SAMPLE_BITS-1:0]  table_q [wto_pkg::TABLE_DEPTH];

  logic [wto_pkg::INDEX_BITS-1:0]          below;
  logic [wto_pkg::LEN_BITS-1:0]            above_inc;
  logic [wto_pkg::INDEX_BITS-1:0]          above;

  // read stage
  logic signed [wto_pkg::SAMPLE_BITS-1:0]  rd_lo_q, rd_hi_q;
  logic                                    s2_valid_q;
  logic                                    s2_zero_q;
  logic [wto_pkg::FRAC_BITS-1:0]           s2_frac_q;

  // multiply stage
  logic signed [wto_pkg::SAMPLE_BITS:0]    diff;
  logic signed [wto_pkg::SAMPLE_BITS:0]    frac_s;
  logic signed [PROD_BITS-1:0]             prod_d, prod_q;
  logic signed [wto_pkg::SAMPLE_BITS-1:0]  s3_lo_q;
  logic                                    s3_valid_q;
  logic                                    s3_zero_q;

  // output stage
  logic signed [PROD_BITS-1:0]             mix;
  logic [wto_pkg::SAMPLE_BITS-1:0]         sample_d;
  logic                                    out_valid_q;
  logic [wto_pkg::SAMPLE_BITS-1:0]         out_data_q;

  // the whole back pipeline moves when the output register is free
  assign adv_o = !out_valid_q || m_axis_tready;

  // neighbor indexes, upper one wraps to the table start
  always_comb begin
    below     = ph_item_i.phase[wto_pkg::PHASE_BITS-1:wto_pkg::FRAC_BITS];
    above_inc = {1'b0, below} + 1'b1;
    above     = (above_inc >= len_i) ? '0 : above_inc[wto_pkg::INDEX_BITS-1:0];
  end

  // table write and two registered reads
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      if (ph_valid_i && !ph_item_i.tick) begin
        table_q[ph_item_i.index] <= ph_item_i.value;
      end
      rd_lo_q <= table_q[below];
      rd_hi_q <= table_q[above];
    end
  end

  // T[lo] * 2^F + (T[hi] - T[lo]) * frac
  always_comb begin
    diff   = (wto_pkg::SAMPLE_BITS+1)'(rd_hi_q) - (wto_pkg::SAMPLE_BITS+1)'(rd_lo_q);
    frac_s = $signed({1'b0, s2_frac_q});
    prod_d = diff * frac_s;
  end

  // round half up and drop fraction bits
  always_comb begin
    mix = prod_q
        + {{(PROD_BITS-wto_pkg::SAMPLE_BITS-wto_pkg::FRAC_BITS){s3_lo_q[wto_pkg::SAMPLE_BITS-1]}},
           s3_lo_q, wto_pkg::FRAC_BITS'(0)}
        + PROD_BITS'(1 << (wto_pkg::FRAC_BITS - 1));
    if (s3_zero_q) begin
      sample_d = '0;
    end else if (interp_i) begin
      sample_d = mix[wto_pkg::FRAC_BITS +: wto_pkg::SAMPLE_BITS];
    end else begin
      sample_d = s3_lo_q;
    end
  end

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      s2_valid_q  <= ph_valid_i && ph_item_i.tick;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      s2_zero_q  <= ph_item_i.zero;
      s2_frac_q  <= ph_item_i.phase[wto_pkg::FRAC_BITS-1:0];
      prod_q     <= prod_d;
      s3_lo_q    <= rd_lo_q;
      s3_zero_q  <= s2_zero_q;
      out_data_q <= sample_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ----- rtl/wavetable_oscillator.sv -----
// top level of the wavetable oscillator
//
// Wavetable oscillator with optional linear interpolation. A load transfer
// (tuser 1) writes one signed 16-bit entry into the 1024-entry table and
// gives no output; a tick transfer (tuser 0) advances the 10.16 fixed-point
// phase by phase_increment, wraps it by table_length entries and gives one
// sample. Entries must be loaded before a tick reads them. Items enter a
// four-deep queue, so the input keeps taking transfers while a result waits.
// Loads, and ticks whose phase and increment both lie below the table span,
// pass the phase unit without a stall, so such a stream runs at one item a
// cycle while the output is taken; a sample passes the queue, the phase
// unit's output register and the read, multiply and output stages. A tick
// whose increment or old phase reaches the span (after a shorter table
// length was set) goes through the bit-serial remainder unit and holds the
// phase unit until the remainder is done. A table length of zero gives
// silent samples and holds the phase; a length above 1024 acts as 1024.
`default_nettype none

module wavetable_oscillator (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [wto_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  wire logic [wto_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // tdata: table_index [9:0], table_value [25:10], zero fill above
  input  wire logic [wto_pkg::S_TDATA_BITS-1:0]     s_axis_tdata,
  // tuser: operation
  input  wire logic                                 s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // tdata: sample
  output logic [wto_pkg::M_TDATA_BITS-1:0]          m_axis_tdata
);

  logic [wto_pkg::INC_BITS-1:0]   inc_q;
  logic                           interp_q;
  logic [wto_pkg::LEN_BITS-1:0]   len_q;
  logic [wto_pkg::LEN_BITS-1:0]   len_eff;

  logic                           q_valid;
  wto_pkg::item_t                 q_item;
  logic                           q_pop;
  logic                           adv;
  logic                           ph_valid;
  wto_pkg::ph_item_t              ph_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q    <= '0;
      interp_q <= 1'b0;
      len_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wto_pkg::CFG_PHASE_INC: inc_q    <= cfg_data_i[wto_pkg::INC_BITS-1:0];
        wto_pkg::CFG_INTERP:    interp_q <= cfg_data_i[0];
        wto_pkg::CFG_TABLE_LEN: len_q    <= cfg_data_i[wto_pkg::LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // length in use is limited to the table depth
  assign len_eff = (len_q > wto_pkg::LEN_BITS'(wto_pkg::TABLE_DEPTH))
                 ? wto_pkg::LEN_BITS'(wto_pkg::TABLE_DEPTH) : len_q;

  wto_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  wto_phase u_phase (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .inc_i      (inc_q),
    .len_i      (len_eff),
    .adv_i      (adv),
    .ph_valid_o (ph_valid),
    .ph_item_o  (ph_item)
  );

  wto_mix u_mix (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ph_valid_i    (ph_valid),
    .ph_item_i     (ph_item),
    .interp_i      (interp_q),
    .len_i         (len_eff),
    .adv_o         (adv),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire
